### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the brace balance scanner checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define BBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Assertion that is also checked during reset.
`define BBS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

### hdl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Types and character codes shared by the brace balance scanner modules.
// ----------------------------------------------------------------------------
package bbs_pkg;

   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;

   localparam int unsigned BALANCE_WIDTH = 16;

   typedef enum logic [1:0] {
      MODE_CODE    = 2'd0,
      MODE_BLOCK   = 2'd1,
      MODE_LITERAL = 2'd2,
      MODE_LINE    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     pending;
      logic     quote_single;
   } lex_state_type;

   typedef struct packed {
      logic up;
      logic down;
   } brace_evt_type;

   typedef struct packed {
      logic [7:0] character;
      logic       line_end;
      logic       range_start;
   } req_type;

   typedef struct packed {
      logic signed [BALANCE_WIDTH-1:0] balance;
      logic                            saturated;
   } rsp_type;

endpackage

### hdl/brace_balance_scanner.sv
// ----------------------------------------------------------------------------
// brace_balance_scanner
// Net curly-brace count over a character stream, skipping comments and
// quoted literals, with a saturating counter and a sticky limit flag.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat contents
//   req_     in         req_valid/req_ready    character, line_end, range_start
//   rsp_     out        rsp_valid/rsp_ready    balance, saturated
//
// One beat in gives one beat out. A character is captured in an input
// register, then lexed and counted into the result register when that
// register is free or draining; the path from input register to result
// register is one lexer step plus one COUNT_WIDTH-bit increment and limit
// compare. Sustained rate is one character per cycle with rsp_ready high.
// Synchronous reset clears the valid flags, lexer state, count and flag.
// A stalled result holds the result register and the input register
// keeps one more character before req_ready drops.
// ----------------------------------------------------------------------------
module brace_balance_scanner #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbs_pkg::rsp_type rsp_data
);
   import bbs_pkg::*;

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // Input stage.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Scanner state.
   lex_state_type                 lex_ff, lex_in;
   logic signed [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                          sat_ff, sat_in;

   // Result stage.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic                          advance;
   logic                          req_take;
   brace_evt_type                 brace;
   logic signed [COUNT_WIDTH-1:0] count_base;
   logic                          sat_base;
   logic signed [31:0]            count_wide;

   // Move the input stage forward when the result slot is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   bbs_lexer u_lexer (
      .state      (lex_ff),
      .item       (in_data_ff),
      .state_next (lex_in),
      .brace      (brace)
   );

   // Count update: range start zeroes the count and the flag first, then a
   // brace at a limit is dropped and marks the flag.
   always_comb begin
      count_base = in_data_ff.range_start ? '0 : count_ff;
      sat_base   = in_data_ff.range_start ? 1'b0 : sat_ff;
      count_in   = count_base;
      sat_in     = sat_base;
      if (brace.up) begin
         if (count_base == COUNT_MAX) begin
            sat_in = 1'b1;
         end else begin
            count_in = count_base + COUNT_WIDTH'(1);
         end
      end else if (brace.down) begin
         if (count_base == COUNT_MIN) begin
            sat_in = 1'b1;
         end else begin
            count_in = count_base - COUNT_WIDTH'(1);
         end
      end
   end

   // Sign-extend to 32 bits, then keep the low balance bits.
   assign count_wide = 32'(count_in);

   always_comb begin
      out_data_in.balance   = count_wide[BALANCE_WIDTH-1:0];
      out_data_in.saturated = sat_in;
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lex_ff       <= '{mode: MODE_CODE, pending: 1'b0, quote_single: 1'b0};
         count_ff     <= '0;
         sat_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            lex_ff   <= lex_in;
            count_ff <= count_in;
            sat_ff   <= sat_in;
         end
      end
   end

   // Payload registers: load on capture, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### hdl/bbs_lexer.sv
// ----------------------------------------------------------------------------
// bbs_lexer
// Lexer state transition for one character: comments, literals, escapes,
// and detection of braces that count.
// ----------------------------------------------------------------------------
module bbs_lexer (
   input  bbs_pkg::lex_state_type state,
   input  bbs_pkg::req_type       item,
   output bbs_pkg::lex_state_type state_next,
   output bbs_pkg::brace_evt_type brace
);
   import bbs_pkg::*;

   lex_state_type cur;
   logic [7:0]    c;
   logic          last;
   logic          scan_plain;
   logic [7:0]    quote_char;

   // Range start drops all lexer state before this character.
   always_comb begin
      cur = item.range_start ? '{mode: MODE_CODE, pending: 1'b0, quote_single: 1'b0}
                             : state;
   end

   assign c          = item.character;
   assign last       = item.line_end;
   assign quote_char = cur.quote_single ? CHAR_SQUOTE : CHAR_DQUOTE;
   // In code, the character is scanned plainly unless it completes a comment opener.
   assign scan_plain = (cur.mode == MODE_CODE) &&
                       !(cur.pending && (c == CHAR_SLASH || c == CHAR_STAR));

   // Next state.
   always_comb begin
      state_next = cur;
      case (cur.mode)
         MODE_CODE: begin
            state_next.pending = 1'b0;
            if (cur.pending && c == CHAR_SLASH) begin
               state_next.mode = MODE_LINE;
            end else if (cur.pending && c == CHAR_STAR) begin
               state_next.mode = MODE_BLOCK;
            end else if (c == CHAR_SLASH) begin
               state_next.pending = !last;
            end else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
               state_next.mode         = MODE_LITERAL;
               state_next.quote_single = (c == CHAR_SQUOTE);
            end
         end
         MODE_BLOCK: begin
            if (cur.pending && c == CHAR_SLASH) begin
               state_next.mode    = MODE_CODE;
               state_next.pending = 1'b0;
            end else begin
               state_next.pending = (c == CHAR_STAR) && !last;
            end
         end
         MODE_LITERAL: begin
            if (cur.pending) begin
               state_next.pending = 1'b0;
            end else if (c == CHAR_BACKSLASH && !last) begin
               state_next.pending = 1'b1;
            end else if (c == quote_char) begin
               state_next.mode = MODE_CODE;
            end
         end
         default: begin
            state_next = cur;
         end
      endcase
      // Line end closes a line comment and drops any pending mark.
      if (last) begin
         state_next.pending = 1'b0;
         if (state_next.mode == MODE_LINE) begin
            state_next.mode = MODE_CODE;
         end
      end
   end

   // Brace events.
   always_comb begin
      brace.up   = scan_plain && (c == CHAR_LBRACE);
      brace.down = scan_plain && (c == CHAR_RBRACE);
   end

endmodule

### hdl/bbs_checker.sv
// ----------------------------------------------------------------------------
// bbs_checker
// Port-level checks for the brace balance scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bbs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bbs_pkg::rsp_type rsp_data
);
   import bbs_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready && (req_data.line_end || !req_data.line_end);

   `BBS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)
   `BBS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `BBS_ASSERT(a_ready_when_out_empty, clock, reset, !rsp_valid |-> req_ready)
   `BBS_ASSERT(a_rsp_follows_req, clock, reset, req_fire |=> ##1 rsp_valid)

endmodule

bind brace_balance_scanner bbs_checker u_bbs_checker (.*);
